### design/kfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_pkg
// Shared codes, field widths, defaults and controller/datapath interface types
// for the keyframe resync frame queues.
// ----------------------------------------------------------------------------
package kfq_pkg;

	localparam int OP_W           = 2;
	localparam int SLOT_FIELD_W   = 3;
	localparam int HANDLE_FIELD_W = 16;
	localparam int MASK_W         = 8;
	localparam int COUNT_FIELD_W  = 4;

	localparam int DEF_MAX_CLIENTS  = 8;
	localparam int DEF_QUEUE_DEPTH  = 8;
	localparam int DEF_HANDLE_WIDTH = 16;

	localparam logic [OP_W-1:0] OP_CONNECT    = 2'd0;
	localparam logic [OP_W-1:0] OP_BROADCAST  = 2'd1;
	localparam logic [OP_W-1:0] OP_DEQUEUE    = 2'd2;
	localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;       // capture the incoming request
		logic exec;         // apply connect or disconnect
		logic meta_rd_slot; // read the addressed slot's queue pointers
		logic bc_first_rd;  // start the broadcast sweep at slot zero
		logic bc_upd;       // update one slot of the broadcast sweep
		logic dq_dat;       // dequeue decision on the pointers just read
		logic dq_st;        // capture the popped handle
		logic lvl_dat;      // capture the addressed slot's level
		logic load_out;     // move the finished result to the output register
	} kfq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dq_hit;
		logic iter_last;
		logic out_free;
	} kfq_sts_t;

endpackage

### design/kfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kfq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/kfq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_ctrl
// Sequencer for the frame queues: steps each request through its memory
// accesses and hands the result to the output register.
// ----------------------------------------------------------------------------
module kfq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kfq_pkg::OP_W-1:0]      operation,
	input  kfq_pkg::kfq_sts_t             sts,
	output kfq_pkg::kfq_cmd_t             cmd
);
	import kfq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EXEC   = 4'd1;
	localparam logic [3:0] S_DQ_RD  = 4'd2;
	localparam logic [3:0] S_DQ_DAT = 4'd3;
	localparam logic [3:0] S_DQ_ST  = 4'd4;
	localparam logic [3:0] S_BC_RD  = 4'd5;
	localparam logic [3:0] S_BC_UPD = 4'd6;
	localparam logic [3:0] S_LV_RD  = 4'd7;
	localparam logic [3:0] S_LV_DAT = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (operation inside {OP_CONNECT, OP_DISCONNECT}) begin
						state_d = S_EXEC;
					end else if (operation == OP_DEQUEUE) begin
						state_d = S_DQ_RD;
					end else begin
						state_d = S_BC_RD;
					end
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_FIN;
			end
			S_DQ_RD: begin
				cmd.meta_rd_slot = 1'b1;
				state_d          = S_DQ_DAT;
			end
			S_DQ_DAT: begin
				cmd.dq_dat = 1'b1;
				state_d    = sts.dq_hit ? S_DQ_ST : S_FIN;
			end
			S_DQ_ST: begin
				cmd.dq_st = 1'b1;
				state_d   = S_FIN;
			end
			S_BC_RD: begin
				cmd.bc_first_rd = 1'b1;
				state_d         = S_BC_UPD;
			end
			S_BC_UPD: begin
				cmd.bc_upd = 1'b1;
				if (sts.iter_last) begin
					state_d = S_LV_RD;
				end
			end
			S_LV_RD: begin
				cmd.meta_rd_slot = 1'b1;
				state_d          = S_LV_DAT;
			end
			S_LV_DAT: begin
				cmd.lvl_dat = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/kfq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_datapath
// Slot flags, queue pointer memory, handle memory, working result and the
// output register of the frame queues.
// ----------------------------------------------------------------------------
module kfq_datapath #(
	parameter int MAX_CLIENTS  = kfq_pkg::DEF_MAX_CLIENTS,
	parameter int QUEUE_DEPTH  = kfq_pkg::DEF_QUEUE_DEPTH,
	parameter int HANDLE_WIDTH = kfq_pkg::DEF_HANDLE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kfq_pkg::kfq_cmd_t                   cmd,
	output kfq_pkg::kfq_sts_t                   sts,
	input  logic [kfq_pkg::OP_W-1:0]            operation,
	input  logic [kfq_pkg::SLOT_FIELD_W-1:0]    client_slot,
	input  logic [kfq_pkg::HANDLE_FIELD_W-1:0]  frame_handle,
	input  logic                                is_keyframe,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                handle_valid,
	output logic [kfq_pkg::HANDLE_FIELD_W-1:0]  handle_out,
	output logic                                request_keyframe,
	output logic [kfq_pkg::MASK_W-1:0]          delivered_mask,
	output logic [kfq_pkg::MASK_W-1:0]          overflow_mask,
	output logic [kfq_pkg::COUNT_FIELD_W-1:0]   active_count,
	output logic [kfq_pkg::COUNT_FIELD_W-1:0]   queue_level
);
	import kfq_pkg::*;

	localparam int SW     = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int HDW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int MW     = HDW + CW;
	localparam int SDEPTH = MAX_CLIENTS * QUEUE_DEPTH;
	localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int HW     = (HANDLE_WIDTH < HANDLE_FIELD_W) ? HANDLE_WIDTH : HANDLE_FIELD_W;
	localparam int ACW    = $clog2(MAX_CLIENTS + 1);

	// Captured request.
	logic [OP_W-1:0] op_q;
	logic [SW-1:0]   slot_q;
	logic            slot_ok_q;
	logic [HW-1:0]   handle_q;
	logic            key_q;

	// Slot state.
	logic [MAX_CLIENTS-1:0] active_q;
	logic [MAX_CLIENTS-1:0] await_q;
	logic [ACW-1:0]         active_cnt_q;
	logic [SW-1:0]          iter_q;

	// Working result.
	logic                      res_valid_q;
	logic [HANDLE_FIELD_W-1:0] res_handle_q;
	logic                      res_req_q;
	logic [MASK_W-1:0]         res_dlv_q;
	logic [MASK_W-1:0]         res_ovf_q;
	logic [CW-1:0]             res_level_q;
	logic                      out_valid_q;

	// Queue pointer memory: {head, count} per slot.
	logic          m_we;
	logic [SW-1:0] m_waddr;
	logic [MW-1:0] m_wdata;
	logic          m_re;
	logic [SW-1:0] m_raddr;
	logic [MW-1:0] m_rdata;

	// Handle memory: QUEUE_DEPTH entries per slot.
	logic           s_we;
	logic [SAW-1:0] s_waddr;
	logic           s_re;
	logic [SAW-1:0] s_raddr;
	logic [HW-1:0]  s_rdata;

	logic [HDW-1:0] m_head;
	logic [CW-1:0]  m_cnt;
	logic [CW-1:0]  cnt_slot;
	logic           dq_hit;
	logic           b_act;
	logic           b_take;
	logic           b_full;
	logic [CW:0]    tail_sum;
	logic [HDW-1:0] tail_off;
	logic [HDW-1:0] next_head;

	assign m_head = m_rdata[MW-1:CW];
	assign m_cnt  = m_rdata[CW-1:0];

	// Pointers of a slot that is not active read as an empty queue.
	assign cnt_slot = (slot_ok_q && active_q[slot_q]) ? m_cnt : '0;
	assign dq_hit   = (cnt_slot != '0);

	assign b_act  = active_q[iter_q];
	assign b_take = b_act && (!await_q[iter_q] || key_q);
	assign b_full = (m_cnt >= CW'(QUEUE_DEPTH));

	assign tail_sum  = (CW+1)'(m_head) + (CW+1)'(m_cnt);
	assign tail_off  = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		HDW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : HDW'(tail_sum);
	assign next_head = (m_head == HDW'(QUEUE_DEPTH - 1)) ? '0 : m_head + 1'b1;

	assign sts.dq_hit    = dq_hit;
	assign sts.iter_last = (iter_q == SW'(MAX_CLIENTS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		m_we    = 1'b0;
		m_waddr = slot_q;
		m_wdata = '0;
		m_re    = 1'b0;
		m_raddr = slot_q;
		if (cmd.exec && slot_ok_q) begin
			m_we = 1'b1;
		end
		if (cmd.meta_rd_slot) begin
			m_re = 1'b1;
		end
		if (cmd.bc_first_rd) begin
			m_re    = 1'b1;
			m_raddr = '0;
		end
		if (cmd.dq_dat && dq_hit) begin
			m_we    = 1'b1;
			m_wdata = {next_head, m_cnt - 1'b1};
		end
		if (cmd.bc_upd) begin
			m_waddr = iter_q;
			if (b_take) begin
				m_we    = 1'b1;
				m_wdata = b_full ? '0 : {m_head, m_cnt + 1'b1};
			end
			if (!sts.iter_last) begin
				m_re    = 1'b1;
				m_raddr = iter_q + 1'b1;
			end
		end
	end

	assign s_we    = cmd.bc_upd && b_take && !b_full;
	assign s_waddr = SAW'(iter_q) * SAW'(QUEUE_DEPTH) + SAW'(tail_off);
	assign s_re    = cmd.dq_dat && dq_hit;
	assign s_raddr = SAW'(slot_q) * SAW'(QUEUE_DEPTH) + SAW'(m_head);

	kfq_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_CLIENTS)
	) u_meta_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	kfq_ram #(
		.WIDTH(HW),
		.DEPTH(SDEPTH)
	) u_store_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(handle_q),
		.re   (s_re),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= operation;
			slot_q    <= SW'(client_slot);
			slot_ok_q <= (int'(client_slot) < MAX_CLIENTS);
			handle_q  <= HW'(frame_handle);
			key_q     <= is_keyframe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			await_q      <= '0;
			active_cnt_q <= '0;
			iter_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				iter_q <= '0;
			end
			if (cmd.exec && slot_ok_q) begin
				if (op_q == OP_CONNECT) begin
					if (!active_q[slot_q]) begin
						active_cnt_q <= active_cnt_q + 1'b1;
					end
					active_q[slot_q] <= 1'b1;
					await_q[slot_q]  <= 1'b1;
				end else begin
					if (active_q[slot_q]) begin
						active_cnt_q <= active_cnt_q - 1'b1;
					end
					active_q[slot_q] <= 1'b0;
					await_q[slot_q]  <= 1'b0;
				end
			end
			if (cmd.bc_upd) begin
				if (b_take) begin
					await_q[iter_q] <= b_full;
				end
				if (!sts.iter_last) begin
					iter_q <= iter_q + 1'b1;
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_valid_q  <= 1'b0;
			res_handle_q <= '0;
			res_req_q    <= 1'b0;
			res_dlv_q    <= '0;
			res_ovf_q    <= '0;
			res_level_q  <= '0;
		end
		if (cmd.exec && slot_ok_q && (op_q == OP_CONNECT)) begin
			res_req_q <= 1'b1;
		end
		if (cmd.dq_dat) begin
			if (dq_hit) begin
				res_valid_q <= 1'b1;
				res_level_q <= m_cnt - 1'b1;
			end else begin
				res_level_q <= cnt_slot;
			end
		end
		if (cmd.dq_st) begin
			res_handle_q <= HANDLE_FIELD_W'(s_rdata);
		end
		if (cmd.bc_upd && b_take) begin
			if (b_full) begin
				res_req_q <= 1'b1;
				if (int'(iter_q) < MASK_W) begin
					res_ovf_q[3'(iter_q)] <= 1'b1;
				end
			end else if (int'(iter_q) < MASK_W) begin
				res_dlv_q[3'(iter_q)] <= 1'b1;
			end
		end
		if (cmd.lvl_dat) begin
			res_level_q <= cnt_slot;
		end
		if (cmd.load_out) begin
			handle_valid     <= res_valid_q;
			handle_out       <= res_handle_q;
			request_keyframe <= res_req_q;
			delivered_mask   <= res_dlv_q;
			overflow_mask    <= res_ovf_q;
			active_count     <= COUNT_FIELD_W'(active_cnt_q);
			queue_level      <= COUNT_FIELD_W'(res_level_q);
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.load_out)
		else $error("result register loaded while a result is still waiting");

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(active_q) == int'(active_cnt_q))
		else $error("active slot counter disagrees with the slot flags");

	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dq_st |-> $past(cmd.dq_dat && dq_hit))
		else $error("handle captured without a dequeue hit in the cycle before");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bc_upd && b_act) |-> (m_cnt <= CW'(QUEUE_DEPTH)))
		else $error("queue count of an active slot exceeds the queue depth");
`endif

endmodule

### design/keyframe_resync_frame_queues.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_resync_frame_queues
// Per-client frame handle queues that drop frames until a keyframe arrives.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and every request gives exactly one
// result. Connect and disconnect pass through the execute state; a dequeue
// reads the slot's queue pointers, decides and pops a handle only when the
// queue is not empty; a broadcast reads slot zero, sweeps every slot and
// then reads the addressed slot's level. Each request ends by loading its
// result into the output register. The sweep through the queue pointer
// memory reads one slot and updates the one before it in each cycle. The
// output register frees the input side: a new request is taken as soon as
// the sequencer is back in idle, even while the previous result still waits
// for out_ready. Both memories need no clearing after reset; a slot's queue
// pointers are rewritten on connect and read as empty while the slot is
// inactive, so the block takes requests as soon as reset is released.
module keyframe_resync_frame_queues #(
	parameter int MAX_CLIENTS  = kfq_pkg::DEF_MAX_CLIENTS,
	parameter int QUEUE_DEPTH  = kfq_pkg::DEF_QUEUE_DEPTH,
	parameter int HANDLE_WIDTH = kfq_pkg::DEF_HANDLE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [kfq_pkg::OP_W-1:0]            operation,
	input  logic [kfq_pkg::SLOT_FIELD_W-1:0]    client_slot,
	input  logic [kfq_pkg::HANDLE_FIELD_W-1:0]  frame_handle,
	input  logic                                is_keyframe,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                handle_valid,
	output logic [kfq_pkg::HANDLE_FIELD_W-1:0]  handle_out,
	output logic                                request_keyframe,
	output logic [kfq_pkg::MASK_W-1:0]          delivered_mask,
	output logic [kfq_pkg::MASK_W-1:0]          overflow_mask,
	output logic [kfq_pkg::COUNT_FIELD_W-1:0]   active_count,
	output logic [kfq_pkg::COUNT_FIELD_W-1:0]   queue_level
);
	import kfq_pkg::*;

	// The sequencer only steers; all slot state and both memories live in
	// the datapath, which reports back the few decisions the sequence needs.
	kfq_cmd_t cmd;
	kfq_sts_t sts;

	kfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.sts      (sts),
		.cmd      (cmd)
	);

	kfq_datapath #(
		.MAX_CLIENTS (MAX_CLIENTS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_WIDTH(HANDLE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.client_slot     (client_slot),
		.frame_handle    (frame_handle),
		.is_keyframe     (is_keyframe),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.handle_valid    (handle_valid),
		.handle_out      (handle_out),
		.request_keyframe(request_keyframe),
		.delivered_mask  (delivered_mask),
		.overflow_mask   (overflow_mask),
		.active_count    (active_count),
		.queue_level     (queue_level)
	);

endmodule

### test/tb_keyframe_resync_frame_queues.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_resync_frame_queues
// Self-checking testbench for the per-client frame queues with keyframe resync.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the slot flags and frame queues and
// predicts the single result of every accepted request. Results are compared
// field by field, in order, as they leave the block. A short directed part
// covers the corner cases (empty broadcast, inactive slots, reconnect, queue
// overflow), then about 1400 random requests follow in phases that favor
// filling, draining or a balanced mix, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_keyframe_resync_frame_queues;
	import kfq_pkg::*;

	localparam int NUM_SLOTS      = 8;
	localparam int SLOT_DEPTH     = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CHUNK_ITEMS    = 200;
	localparam int NUM_CHUNKS     = 7;

	// One result of the block, in the order of its output ports.
	typedef struct packed {
		logic                         handle_valid;
		logic [HANDLE_FIELD_W-1:0]    handle_out;
		logic                         request_keyframe;
		logic [MASK_W-1:0]            delivered_mask;
		logic [MASK_W-1:0]            overflow_mask;
		logic [COUNT_FIELD_W-1:0]     active_count;
		logic [COUNT_FIELD_W-1:0]     queue_level;
	} frame_result_t;

	// Shadow copy of the slot state. Every accepted request updates it and
	// queues the result the block has to produce for that request.
	class frame_queue_scoreboard;
		bit                        slot_active [NUM_SLOTS];
		bit                        awaiting_key[NUM_SLOTS];
		logic [HANDLE_FIELD_W-1:0] frame_store [NUM_SLOTS*SLOT_DEPTH];
		logic [2:0]                read_ptr    [NUM_SLOTS];
		logic [3:0]                fill_level  [NUM_SLOTS];
		frame_result_t             pending_results[$];
		int                        errors;

		function new();
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_active[s]  = 1'b0;
				awaiting_key[s] = 1'b0;
				read_ptr[s]     = '0;
				fill_level[s]   = '0;
			end
			errors = 0;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [SLOT_FIELD_W-1:0] slot,
				logic [HANDLE_FIELD_W-1:0] handle, logic key);
			frame_result_t res;
			logic [2:0]    wr_ptr;
			res = '0;
			case (op)
				OP_CONNECT: begin
					slot_active[slot]  = 1'b1;
					awaiting_key[slot] = 1'b1;
					read_ptr[slot]     = '0;
					fill_level[slot]   = '0;
					res.request_keyframe = 1'b1;
				end
				OP_BROADCAST: begin
					for (int s = 0; s < NUM_SLOTS; s++) begin
						// An awaiting slot only wakes up on a keyframe; a full queue
						// is flushed and the slot starts waiting again.
						if (slot_active[s] && (!awaiting_key[s] || key)) begin
							awaiting_key[s] = 1'b0;
							if (fill_level[s] >= SLOT_DEPTH) begin
								read_ptr[s]     = '0;
								fill_level[s]   = '0;
								awaiting_key[s] = 1'b1;
								res.request_keyframe = 1'b1;
								res.overflow_mask[s] = 1'b1;
							end else begin
								wr_ptr = read_ptr[s] + fill_level[s][2:0];
								frame_store[s*SLOT_DEPTH + wr_ptr] = handle;
								fill_level[s]++;
								res.delivered_mask[s] = 1'b1;
							end
						end
					end
				end
				OP_DEQUEUE: begin
					if (slot_active[slot] && fill_level[slot] != 0) begin
						res.handle_valid = 1'b1;
						res.handle_out   = frame_store[slot*SLOT_DEPTH + read_ptr[slot]];
						read_ptr[slot]++;
						fill_level[slot]--;
					end
				end
				OP_DISCONNECT: begin
					slot_active[slot]  = 1'b0;
					awaiting_key[slot] = 1'b0;
					read_ptr[slot]     = '0;
					fill_level[slot]   = '0;
				end
			endcase
			for (int s = 0; s < NUM_SLOTS; s++)
				res.active_count += slot_active[s];
			res.queue_level = fill_level[slot];
			pending_results = {pending_results, res};
		endfunction

		function void compare_field(string name, longint unsigned exp_val,
				longint unsigned act_val);
			if (exp_val != act_val) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t exp_res;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			exp_res = pending_results[0];
			pending_results.delete(0);
			compare_field("handle_valid", exp_res.handle_valid, got.handle_valid);
			compare_field("handle_out", exp_res.handle_out, got.handle_out);
			compare_field("request_keyframe", exp_res.request_keyframe, got.request_keyframe);
			compare_field("delivered_mask", exp_res.delivered_mask, got.delivered_mask);
			compare_field("overflow_mask", exp_res.overflow_mask, got.overflow_mask);
			compare_field("active_count", exp_res.active_count, got.active_count);
			compare_field("queue_level", exp_res.queue_level, got.queue_level);
		endfunction
	endclass

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	logic [OP_W-1:0]            operation    = OP_CONNECT;
	logic [SLOT_FIELD_W-1:0]    client_slot  = '0;
	logic [HANDLE_FIELD_W-1:0]  frame_handle = '0;
	logic                       is_keyframe  = 1'b0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic                       handle_valid;
	logic [HANDLE_FIELD_W-1:0]  handle_out;
	logic                       request_keyframe;
	logic [MASK_W-1:0]          delivered_mask;
	logic [MASK_W-1:0]          overflow_mask;
	logic [COUNT_FIELD_W-1:0]   active_count;
	logic [COUNT_FIELD_W-1:0]   queue_level;

	// When cleared, neither side inserts idle cycles.
	bit                         idling = 1'b1;
	int                         quiet_cycles = 0;
	frame_queue_scoreboard      sb = new();

	keyframe_resync_frame_queues i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.client_slot     (client_slot),
		.frame_handle    (frame_handle),
		.is_keyframe     (is_keyframe),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.handle_valid    (handle_valid),
		.handle_out      (handle_out),
		.request_keyframe(request_keyframe),
		.delivered_mask  (delivered_mask),
		.overflow_mask   (overflow_mask),
		.active_count    (active_count),
		.queue_level     (queue_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls in roughly one cycle of five while idling is enabled.
	always @(posedge clk) begin
		out_ready <= !idling || ($urandom_range(0, 99) >= 20);
	end

	// Result checking and the watchdog. Both sample the values from before the
	// edge, since every stimulus change is a nonblocking update at the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result({handle_valid, handle_out, request_keyframe, delivered_mask,
					overflow_mask, active_count, queue_level});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Presents one request and returns at the edge where it is accepted. A
	// random gap with valid low may come first. Valid is only lowered when a
	// gap follows, so it never toggles within one time step.
	task automatic send_request(input logic [OP_W-1:0] op,
			input logic [SLOT_FIELD_W-1:0] slot, input logic [HANDLE_FIELD_W-1:0] handle,
			input logic key);
		int gap;
		gap = (idling && $urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		client_slot  <= slot;
		frame_handle <= handle;
		is_keyframe  <= key;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(op, slot, handle, key);
	endtask

	// Holds the sender off until every predicted result has been seen.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int                        pick;
		int                        conn_w;
		int                        bcast_w;
		int                        deq_w;
		logic [OP_W-1:0]           op;
		logic [HANDLE_FIELD_W-1:0] handle;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A broadcast with nobody connected, then requests to
		// slots that were never connected.
		send_request(OP_BROADCAST, 3'd7, 16'hFFFF, 1'b1);
		send_request(OP_DEQUEUE, 3'd0, 16'h0000, 1'b0);
		send_request(OP_DISCONNECT, 3'd5, 16'h0000, 1'b0);

		// Two clients join; a plain frame is dropped while they wait for a
		// keyframe, the keyframe releases them and a plain frame follows.
		send_request(OP_CONNECT, 3'd0, 16'h0000, 1'b0);
		send_request(OP_CONNECT, 3'd7, 16'h0000, 1'b0);
		send_request(OP_BROADCAST, 3'd0, 16'h1234, 1'b0);
		send_request(OP_BROADCAST, 3'd7, 16'h0000, 1'b1);
		send_request(OP_BROADCAST, 3'd0, 16'hFFFF, 1'b0);

		// Slot 0 is drained past empty, and slot 7 reconnects while active.
		send_request(OP_DEQUEUE, 3'd0, 16'h0000, 1'b0);
		send_request(OP_DEQUEUE, 3'd0, 16'h0000, 1'b0);
		send_request(OP_DEQUEUE, 3'd0, 16'h0000, 1'b0);
		send_request(OP_CONNECT, 3'd7, 16'hFFFF, 1'b1);

		// Nine keyframes fill both queues and the ninth overflows them.
		for (int k = 0; k < 9; k++)
			send_request(OP_BROADCAST, k[2:0], 16'hA500 + k[15:0], 1'b1);
		send_request(OP_DEQUEUE, 3'd7, 16'h0000, 1'b0);
		send_request(OP_DISCONNECT, 3'd0, 16'h0000, 1'b0);
		send_request(OP_DISCONNECT, 3'd7, 16'h0000, 1'b0);

		// The sender waits for every outstanding result before going on.
		wait_drained();

		// Random part in phases: balanced, filling and draining mixes. One
		// phase runs with no idling on either side, and before another the
		// sender pauses again until the block is drained.
		for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
			idling = (chunk != 3);
			if (chunk == 4)
				wait_drained();
			case (chunk % 3)
				0: begin conn_w = 10; bcast_w = 40; deq_w = 40; end
				1: begin conn_w = 6;  bcast_w = 70; deq_w = 18; end
				default: begin conn_w = 10; bcast_w = 25; deq_w = 60; end
			endcase
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < conn_w)
					op = OP_CONNECT;
				else if (pick < conn_w + bcast_w)
					op = OP_BROADCAST;
				else if (pick < conn_w + bcast_w + deq_w)
					op = OP_DEQUEUE;
				else
					op = OP_DISCONNECT;
				case ($urandom_range(0, 9))
					0: handle = 16'h0000;
					1: handle = 16'hFFFF;
					default: handle = HANDLE_FIELD_W'($urandom_range(0, 16'hFFFF));
				endcase
				send_request(op, SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1)), handle,
					$urandom_range(0, 99) < 30);
			end
		end

		// Let the last results come out, then keep watching for anything the
		// block might still emit by mistake.
		idling = 1'b1;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
